// ===== rtl/core/scba_pkg.sv =====
package scba_pkg;

  localparam int CLASS_COUNT_DEF     = 7;
  localparam int PAGES_PER_CLASS_DEF = 1;
  localparam int PAGE_BYTES          = 4096;
  localparam int BITMAP_WORDS_DEF    = 4;
  localparam int MAX_CLASSES         = 7;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_QUERY = 2'd2,
    OP_BAD   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_FULL      = 3'd2,
    ST_OUTSIDE   = 3'd3,
    ST_NOT_USED  = 3'd4
  } status_t;

  // Slot capacity of a class: min(region slots, bitmap bits, 255).
  function automatic int class_capacity(input int c, input int pages, input int words);
    int slots;
    slots = (pages * PAGE_BYTES) >> (c + 5);
    if (slots > words * 32) slots = words * 32;
    if (slots > 255) slots = 255;
    return slots;
  endfunction

endpackage

// ===== rtl/core/size_class_bitmap_allocator_top.sv =====
// Channel   | Direction | Ports
// ----------+-----------+------------------------------------------------
// request   | in        | in_valid, in_stall, in_op, in_req_size, in_address
// result    | out       | out_valid, out_stall, out_status, out_block_address,
//           |           | out_block_size, out_in_region
// config    | in        | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// A request is taken whenever the sequencer is idle. A bad opcode or size goes straight to the
// result; an allocate scans one bitmap word per cycle, a query checks one region per cycle,
// and a free runs region search, slot shift and bitmap update. A finished result moves to the
// output register; while that register holds a stalled result, the next request waits at its
// last step. Reset (rst_n, synchronous) clears bitmaps and bases.
module size_class_bitmap_allocator_top #(
  parameter int CLASS_COUNT     = scba_pkg::CLASS_COUNT_DEF,
  parameter int PAGES_PER_CLASS = scba_pkg::PAGES_PER_CLASS_DEF,
  parameter int BITMAP_WORDS    = scba_pkg::BITMAP_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [11:0] in_req_size,
  input  logic [31:0] in_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [31:0] out_block_address,
  output logic [11:0] out_block_size,
  output logic        out_in_region,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int WW = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int NW = CLASS_COUNT * BITMAP_WORDS;
  localparam int NWW = (NW > 1) ? $clog2(NW) : 1;
  localparam int SW = $clog2(BITMAP_WORDS * 32) + 1;
  localparam int CMPW = (SW > 8) ? SW : 8;
  localparam logic [31:0] SLOT_MAX = 32'(2**SW - 1);
  localparam logic [32:0] REGION = 33'(PAGES_PER_CLASS * scba_pkg::PAGE_BYTES);

  typedef enum logic [6:0] {
    S_IDLE   = 7'b0000001,
    S_SCAN   = 7'b0000010,
    S_REGION = 7'b0000100,
    S_DIV    = 7'b0001000,
    S_FREEB  = 7'b0010000,
    S_WRITE  = 7'b0100000,
    S_OUT    = 7'b1000000
  } state_t;

  state_t state_r;

  logic [31:0] base_r [scba_pkg::MAX_CLASSES];
  logic [31:0] bitmap_r [NW];
  logic [7:0]  fcount_r [CLASS_COUNT];

  logic [1:0]  op_r;
  logic [31:0] addr_r;
  logic [2:0]  cls_r;
  logic [WW:0] widx_r;
  logic [31:0] rem_r;
  logic [SW-1:0] slot_r;
  logic [2:0]  st_r;
  logic [31:0] oaddr_r;
  logic [11:0] osize_r;
  logic        oinr_r;
  logic        ovalid_r;
  logic [2:0]  res_status_r;
  logic [31:0] res_addr_r;
  logic [11:0] res_size_r;
  logic        res_inr_r;

  assign pready = 1'b1;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = ovalid_r;
  assign out_status = res_status_r;
  assign out_block_address = res_addr_r;
  assign out_block_size = res_size_r;
  assign out_in_region = res_inr_r;

  always_comb begin
    prdata = '0;
    if (paddr[4:2] < 3'(scba_pkg::MAX_CLASSES)) prdata = base_r[paddr[4:2]];
  end

  // Size to class: smallest class whose block size covers the request.
  logic [2:0] req_cls;
  logic       req_ok;
  always_comb begin
    req_cls = 3'd7;
    for (int c = scba_pkg::MAX_CLASSES - 1; c >= 0; c--) begin
      if ({20'd0, in_req_size} <= (32'd32 << c)) req_cls = 3'(c);
    end
    req_ok = (in_req_size != 12'd0) && (in_req_size <= 12'd2048) &&
             ({1'b0, req_cls} < 4'(CLASS_COUNT));
  end

  logic [11:0] csize;
  assign csize = 12'd32 << cls_r;

  logic [7:0] cap_cur;
  always_comb begin
    cap_cur = '0;
    for (int c = 0; c < CLASS_COUNT; c++) begin
      if (cls_r == 3'(c))
        cap_cur = 8'(scba_pkg::class_capacity(c, PAGES_PER_CLASS, BITMAP_WORDS));
    end
  end

  // Current bitmap word and its lowest clear bit.
  logic [NWW-1:0] wsel;
  logic [31:0]    wcur;
  logic [4:0]     ffz;
  logic           ffz_hit;
  logic [SW-1:0]  scan_slot;
  assign wsel = NWW'(cls_r * BITMAP_WORDS + widx_r[WW-1:0]);
  assign wcur = bitmap_r[wsel];
  always_comb begin
    ffz = '0;
    ffz_hit = 1'b0;
    for (int b = 31; b >= 0; b--) begin
      if (!wcur[b]) begin
        ffz = 5'(b);
        ffz_hit = 1'b1;
      end
    end
    scan_slot = SW'({widx_r[WW-1:0], ffz});
    if (BITMAP_WORDS == 1) scan_slot = SW'(ffz);
  end

  // Region compare for the class under cls_r, no wrap.
  logic in_cur;
  assign in_cur = ({1'b0, addr_r} >= {1'b0, base_r[cls_r]}) &&
                  ({1'b0, addr_r} < ({1'b0, base_r[cls_r]} + REGION));

  // Class sizes are powers of two, so the slot index is one right shift.
  logic [31:0] div_q;
  assign div_q = rem_r >> (4'(cls_r) + 4'd5);

  // Free slot word and bit.
  logic [NWW-1:0] fsel;
  logic [31:0]    fword;
  logic           fbit;
  assign fsel = NWW'(cls_r * BITMAP_WORDS + 32'(slot_r >> 5));
  assign fword = bitmap_r[fsel];
  assign fbit = fword[slot_r[4:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
      for (int c = 0; c < scba_pkg::MAX_CLASSES; c++) base_r[c] <= '0;
      for (int i = 0; i < NW; i++) bitmap_r[i] <= '0;
      for (int c = 0; c < CLASS_COUNT; c++)
        fcount_r[c] <= 8'(scba_pkg::class_capacity(c, PAGES_PER_CLASS, BITMAP_WORDS));
    end else begin
      if (psel && penable && pwrite && paddr[4:2] < 3'(scba_pkg::MAX_CLASSES))
        base_r[paddr[4:2]] <= pwdata;
      // The output register loads a finished result once the previous one is taken.
      if (state_r == S_OUT && (!ovalid_r || !out_stall)) begin
        ovalid_r <= 1'b1;
        res_status_r <= st_r;
        res_addr_r <= oaddr_r;
        res_size_r <= osize_r;
        res_inr_r <= oinr_r;
      end else if (ovalid_r && !out_stall) begin
        ovalid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r <= in_op;
            addr_r <= in_address;
            oaddr_r <= '0;
            osize_r <= '0;
            oinr_r <= 1'b0;
            widx_r <= '0;
            cls_r <= (in_op == scba_pkg::OP_ALLOC) ? req_cls : 3'd0;
            if (in_op == scba_pkg::OP_ALLOC) begin
              if (!req_ok) begin
                st_r <= scba_pkg::ST_BAD_SIZE;
                state_r <= S_OUT;
              end else begin
                state_r <= S_SCAN;
              end
            end else if (in_op == scba_pkg::OP_BAD) begin
              st_r <= scba_pkg::ST_BAD_SIZE;
              state_r <= S_OUT;
            end else begin
              state_r <= S_REGION;
            end
          end
        end
        S_SCAN: begin
          osize_r <= csize;
          st_r <= scba_pkg::ST_FULL;
          if (fcount_r[cls_r] == 8'd0 || widx_r >= (WW+1)'(BITMAP_WORDS)) begin
            state_r <= S_OUT;
          end else if (ffz_hit) begin
            if (CMPW'(cap_cur) > CMPW'(scan_slot)) begin
              slot_r <= scan_slot;
              state_r <= S_WRITE;
            end else begin
              state_r <= S_OUT;
            end
          end else begin
            widx_r <= widx_r + (WW+1)'(1);
          end
        end
        S_WRITE: begin
          if (op_r == scba_pkg::OP_ALLOC) begin
            bitmap_r[fsel][slot_r[4:0]] <= 1'b1;
            fcount_r[cls_r] <= fcount_r[cls_r] - 8'd1;
            oaddr_r <= base_r[cls_r] + (32'(slot_r) << (4'(cls_r) + 4'd5));
            oinr_r <= 1'b1;
            st_r <= scba_pkg::ST_OK;
          end
          state_r <= S_OUT;
        end
        S_REGION: begin
          if ({1'b0, cls_r} >= 4'(CLASS_COUNT)) begin
            st_r <= scba_pkg::ST_OUTSIDE;
            state_r <= S_OUT;
          end else if (in_cur) begin
            osize_r <= csize;
            oinr_r <= 1'b1;
            st_r <= scba_pkg::ST_OK;
            rem_r <= addr_r - base_r[cls_r];
            state_r <= (op_r == scba_pkg::OP_FREE) ? S_DIV : S_OUT;
          end else begin
            cls_r <= cls_r + 3'd1;
          end
        end
        S_DIV: begin
          slot_r <= SW'((div_q > SLOT_MAX) ? SLOT_MAX : div_q);
          state_r <= S_FREEB;
        end
        S_FREEB: begin
          if (CMPW'(cap_cur) <= CMPW'(slot_r) || !fbit) begin
            st_r <= scba_pkg::ST_NOT_USED;
          end else begin
            bitmap_r[fsel][slot_r[4:0]] <= 1'b0;
            if (fcount_r[cls_r] < cap_cur) fcount_r[cls_r] <= fcount_r[cls_r] + 8'd1;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!ovalid_r || !out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/size_class_bitmap_allocator_top_tb.sv =====
`timescale 1ns / 100ps

module size_class_bitmap_allocator_top_tb;

  localparam int CLASSES = scba_pkg::CLASS_COUNT_DEF;
  localparam int WORDS = scba_pkg::BITMAP_WORDS_DEF;
  localparam longint REGION = longint'(scba_pkg::PAGES_PER_CLASS_DEF) * scba_pkg::PAGE_BYTES;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    scba_pkg::op_t op;
    logic [11:0]   req_size;
    logic [31:0]   address;
  } request_t;

  typedef struct packed {
    scba_pkg::status_t status;
    logic [31:0]       block_address;
    logic [11:0]       block_size;
    logic              in_region;
  } reply_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_op;
  logic [11:0] in_req_size;
  logic [31:0] in_address;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  out_status;
  logic [31:0] out_block_address;
  logic [11:0] out_block_size;
  logic        out_in_region;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  size_class_bitmap_allocator_top u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op),
    .in_req_size(in_req_size), .in_address(in_address),
    .out_valid(out_valid), .out_stall(out_stall), .out_status(out_status),
    .out_block_address(out_block_address), .out_block_size(out_block_size),
    .out_in_region(out_in_region),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Clock with a 10 ns period.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the allocator state, updated as each request is accepted.
  logic [31:0] shadow_base[CLASSES];
  logic [31:0] shadow_bitmap[CLASSES][WORDS];
  int          shadow_free[CLASSES];

  request_t pending_requests[$];
  reply_t   expected_replies[$];
  int       error_count;
  int       idle_cycles;
  int       accepted_count;
  int       reply_count;
  int       op_seen[4];
  int       status_seen[5];
  bit       hold_sender;

  // Sender and receiver idling controls.
  int  burst_left;
  int  gap_left;
  int  stall_mode;
  int  stall_phase;

  function automatic int capacity_of(int c);
    longint slots;
    slots = REGION / (32 << c);
    if (slots > WORDS * 32) slots = WORDS * 32;
    if (slots > 255) slots = 255;
    return int'(slots);
  endfunction

  // The smallest class whose block size fits, or -1 for a bad size.
  function automatic int class_for_size(logic [11:0] sz);
    if (sz == 0 || sz > 2048) return -1;
    for (int c = 0; c < scba_pkg::MAX_CLASSES; c++)
      if (sz <= (32 << c)) return (c < CLASSES) ? c : -1;
    return -1;
  endfunction

  // Lowest class whose region holds the address; overlaps go to the lowest.
  function automatic int region_of(logic [31:0] addr);
    for (int c = 0; c < CLASSES; c++)
      if ({32'd0, addr} >= {32'd0, shadow_base[c]} &&
          longint'({32'd0, addr}) < longint'({32'd0, shadow_base[c]}) + REGION)
        return c;
    return -1;
  endfunction

  function automatic reply_t predict_allocator(request_t rq);
    reply_t r;
    int     c;
    int     cap;
    int     slot;
    r = '{status: scba_pkg::ST_BAD_SIZE, block_address: '0, block_size: '0, in_region: 1'b0};
    if (rq.op == scba_pkg::OP_ALLOC) begin
      c = class_for_size(rq.req_size);
      if (c >= 0) begin
        r.block_size = 12'(32 << c);
        r.status = scba_pkg::ST_FULL;
        cap = capacity_of(c);
        if (shadow_free[c] != 0) begin
          slot = cap;
          for (int s = 0; s < cap; s++)
            if (!shadow_bitmap[c][s / 32][s % 32]) begin
              slot = s;
              break;
            end
          if (slot < cap) begin
            shadow_bitmap[c][slot / 32][slot % 32] = 1'b1;
            shadow_free[c]--;
            r.block_address = shadow_base[c] + 32'(slot) * 32'(32 << c);
            r.in_region = 1'b1;
            r.status = scba_pkg::ST_OK;
          end
        end
      end
    end else if (rq.op == scba_pkg::OP_FREE || rq.op == scba_pkg::OP_QUERY) begin
      c = region_of(rq.address);
      if (c < 0) begin
        r.status = scba_pkg::ST_OUTSIDE;
      end else begin
        r.block_size = 12'(32 << c);
        r.in_region = 1'b1;
        r.status = scba_pkg::ST_OK;
        if (rq.op == scba_pkg::OP_FREE) begin
          slot = int'((rq.address - shadow_base[c]) / (32 << c));
          cap = capacity_of(c);
          if (slot >= cap || !shadow_bitmap[c][slot / 32][slot % 32]) begin
            r.status = scba_pkg::ST_NOT_USED;
          end else begin
            shadow_bitmap[c][slot / 32][slot % 32] = 1'b0;
            if (shadow_free[c] < cap) shadow_free[c]++;
          end
        end
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at %0t: %s got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Driver: presents pending requests in bursts separated by random gaps.
  // The valid stays high across back-to-back requests without being dropped.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_replies.push_back(predict_allocator(pending_requests.pop_front()));
        accepted_count++;
      end
      if (in_valid && in_stall) begin
        // A stalled request stays unchanged.
      end else if (pending_requests.size() > 0 && !hold_sender && gap_left == 0) begin
        in_valid    <= 1'b1;
        in_op       <= pending_requests[0].op;
        in_req_size <= pending_requests[0].req_size;
        in_address  <= pending_requests[0].address;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end
    end
  end

  // Monitor: the receiver stalls on its own rotating pattern, and each
  // accepted result is compared with the oldest prediction.
  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        reply_count++;
        if (expected_replies.size() == 0) begin
          report_mismatch("unexpected result, status", 32'(out_status), 32'hx);
        end else begin
          want = expected_replies.pop_front();
          status_seen[want.status]++;
          if (out_status !== want.status)
            report_mismatch("status", 32'(out_status), 32'(want.status));
          if (out_block_address !== want.block_address)
            report_mismatch("block_address", out_block_address, want.block_address);
          if (out_block_size !== want.block_size)
            report_mismatch("block_size", 32'(out_block_size), 32'(want.block_size));
          if (out_in_region !== want.in_region)
            report_mismatch("in_region", 32'(out_in_region), 32'(want.in_region));
        end
      end
      stall_phase++;
      if (stall_phase >= 64) begin
        stall_phase = 0;
        stall_mode = $urandom_range(0, 3);
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= (stall_phase % 7) < 4;
        default: out_stall <= ($urandom_range(0, 1) == 0);
      endcase
    end
  end

  // Watchdog on cycles with no accepted request, result or configuration access.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n ||
        (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no progress with %0d results outstanding",
                 expected_replies.size());
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Writes one base register through the configuration port.
  task automatic write_base(int idx, logic [31:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(4 * idx);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_base[idx] = value;
  endtask

  // Waits for the block to go quiet before touching its registers.
  task automatic wait_drained();
    while (pending_requests.size() > 0 || in_valid || expected_replies.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] random_address();
    int c;
    c = $urandom_range(0, CLASSES - 1);
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return shadow_base[c] + 32'(REGION) - 32'($urandom_range(1, 64));
      2: return shadow_base[c] + 32'(REGION) + 32'($urandom_range(0, 64));
      3: return shadow_base[c] - 32'($urandom_range(1, 64));
      default: return shadow_base[c] + 32'($urandom_range(0, 31)) * 32'(32 << c) +
                      (($urandom_range(0, 3) == 0) ? 32'($urandom_range(1, 31)) : 32'd0);
    endcase
  endfunction

  function automatic logic [11:0] random_size();
    case ($urandom_range(0, 9))
      0: return 12'($urandom);
      1: return 12'd0;
      2: return 12'(2048 + $urandom_range(1, 2047));
      default: return 12'($urandom_range(1, 32 << $urandom_range(0, CLASSES - 1)));
    endcase
  endfunction

  // Mostly allocate and free, so the bitmaps both fill and drain; the rest
  // are queries and the undefined opcode.
  task automatic queue_random(int n);
    request_t rq;
    for (int i = 0; i < n; i++) begin
      rq.req_size = random_size();
      rq.address = random_address();
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8: rq.op = scba_pkg::OP_ALLOC;
        9, 10, 11, 12, 13, 14, 15: rq.op = scba_pkg::OP_FREE;
        16, 17, 18: rq.op = scba_pkg::OP_QUERY;
        default: rq.op = scba_pkg::OP_BAD;
      endcase
      pending_requests.push_back(rq);
      op_seen[rq.op]++;
    end
  endtask

  task automatic queue_one(scba_pkg::op_t op, logic [11:0] sz, logic [31:0] addr);
    pending_requests.push_back('{op: op, req_size: sz, address: addr});
    op_seen[op]++;
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_op = '0;
    in_req_size = '0;
    in_address = '0;
    out_stall = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    error_count = 0;
    idle_cycles = 0;
    accepted_count = 0;
    reply_count = 0;
    hold_sender = 1'b0;
    burst_left = 0;
    gap_left = 0;
    stall_mode = 0;
    stall_phase = 0;
    op_seen = '{default: 0};
    status_seen = '{default: 0};
    for (int c = 0; c < CLASSES; c++) begin
      shadow_base[c] = '0;
      shadow_free[c] = capacity_of(c);
      for (int w = 0; w < WORDS; w++) shadow_bitmap[c][w] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: with all bases at zero every region overlaps and class 0 wins.
    queue_one(scba_pkg::OP_QUERY, 12'd0, 32'd0);
    queue_one(scba_pkg::OP_QUERY, 12'd0, 32'hFFFF_FFFF);
    queue_one(scba_pkg::OP_BAD, 12'hFFF, 32'hFFFF_FFFF);
    queue_one(scba_pkg::OP_FREE, 12'd0, 32'd64);
    wait_drained();

    // Disjoint regions, one page apart.
    for (int c = 0; c < CLASSES; c++) write_base(c, 32'h1000_0000 + 32'(c) * 32'h1000);
    queue_one(scba_pkg::OP_ALLOC, 12'd0, 32'd0);
    queue_one(scba_pkg::OP_ALLOC, 12'd2049, 32'd0);
    queue_one(scba_pkg::OP_ALLOC, 12'hFFF, 32'd0);
    queue_one(scba_pkg::OP_ALLOC, 12'd1, 32'd0);
    queue_one(scba_pkg::OP_ALLOC, 12'd32, 32'd0);
    queue_one(scba_pkg::OP_ALLOC, 12'd33, 32'd0);
    queue_one(scba_pkg::OP_ALLOC, 12'd2048, 32'd0);
    queue_one(scba_pkg::OP_ALLOC, 12'd2048, 32'd0);
    // The 2048-byte class holds two blocks, so the third is a full class.
    queue_one(scba_pkg::OP_ALLOC, 12'd1500, 32'd0);
    queue_one(scba_pkg::OP_FREE, 12'd0, 32'h1000_6800);
    queue_one(scba_pkg::OP_FREE, 12'd0, 32'h1000_6800);
    queue_one(scba_pkg::OP_FREE, 12'd0, 32'h1000_0021);
    queue_one(scba_pkg::OP_QUERY, 12'd0, 32'h1000_6FFF);
    queue_one(scba_pkg::OP_QUERY, 12'd0, 32'h1000_7000);
    queue_one(scba_pkg::OP_FREE, 12'd0, 32'h0FFF_FFFF);
    // 32-byte class: capacity 128 covers the whole region, so this slot has a bit but is not used.
    queue_one(scba_pkg::OP_FREE, 12'd0, 32'h1000_0F00);
    for (int i = 0; i < 130; i++) queue_one(scba_pkg::OP_ALLOC, 12'd16, 32'd0);
    wait_drained();

    // Top of the address space: the class 0 region ends beyond 2^32 and does not wrap.
    for (int c = 0; c < CLASSES; c++) write_base(c, 32'hFFFF_F800 - 32'(c) * 32'h2000);
    queue_one(scba_pkg::OP_ALLOC, 12'd2048, 32'd0);
    queue_one(scba_pkg::OP_ALLOC, 12'd32, 32'd0);
    queue_one(scba_pkg::OP_QUERY, 12'd0, 32'hFFFF_FFFF);
    queue_random(200);

    // Pause the sender until every result has come back.
    while (pending_requests.size() > 0 || in_valid) @(posedge clk);
    hold_sender = 1'b1;
    queue_random(50);
    while (expected_replies.size() > 0) @(posedge clk);
    hold_sender = 1'b0;
    wait_drained();

    // Random overlapping bases near zero, then random bases anywhere.
    for (int c = 0; c < CLASSES; c++) write_base(c, 32'($urandom_range(0, 3)) * 32'h800);
    queue_random(200);
    wait_drained();
    for (int c = 0; c < CLASSES; c++) write_base(c, $urandom);
    queue_random(200);
    wait_drained();

    $display("covered %0d requests (alloc %0d, free %0d, query %0d, bad op %0d)",
             accepted_count, op_seen[scba_pkg::OP_ALLOC], op_seen[scba_pkg::OP_FREE],
             op_seen[scba_pkg::OP_QUERY], op_seen[scba_pkg::OP_BAD]);
    $display("results by status: ok %0d, bad size %0d, full %0d, outside %0d, not used %0d",
             status_seen[scba_pkg::ST_OK], status_seen[scba_pkg::ST_BAD_SIZE],
             status_seen[scba_pkg::ST_FULL], status_seen[scba_pkg::ST_OUTSIDE],
             status_seen[scba_pkg::ST_NOT_USED]);
    if (error_count == 0 && expected_replies.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/scba_pkg.sv
rtl/core/size_class_bitmap_allocator_top.sv
tb/size_class_bitmap_allocator_top_tb.sv
